// ===== sv/npc_pkg.sv =====
// ============================================================================
// npc_pkg
// Shared types and constants of the nearest palette color block.
// ============================================================================
`default_nettype none

package npc_pkg;

  // Palette capacity and derived widths
  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

  // Full-scale channel value used by the brightening step
  localparam logic [7:0] CHAN_FULL = 8'hFF;

  // Brightening divider: numerator 2*255*c + m, divisor 2*m, 8-bit quotient
  localparam int NUM_W = 17;
  localparam int DEN_W = 9;
  localparam int QUO_W = 8;

  // Squared distance, its root and the root pipeline depth
  localparam int DIST_W      = 18;
  localparam int ERR_W       = 9;
  localparam int SQRT_STAGES = 9;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_QUERY = 1'b1
  } npc_func_t;

  typedef struct packed {
    logic       func;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } npc_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } npc_out_t;

  // Classified word held in the queue
  typedef struct packed {
    npc_func_t  func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] chan_max;
  } npc_qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } npc_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } npc_state_t;

endpackage

`default_nettype wire

// ===== sv/npc_front.sv =====
// ============================================================================
// npc_front
// Input stage: accepts a word, finds the largest channel and hands the
// classified word to the queue.
// ============================================================================
`default_nettype none

module npc_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  npc_pkg::npc_in_t    in_data,
  output logic                q_push,
  output npc_pkg::npc_qitem_t q_push_data,
  input  npc_pkg::npc_qstat_t q_stat
);

  logic                fr_valid_r;
  npc_pkg::npc_qitem_t fr_item_r;
  npc_pkg::npc_qitem_t fr_item_nxt;
  logic [7:0]          chan_max;

  always_comb begin
    chan_max = in_data.red_in;
    if (in_data.green_in > chan_max) begin
      chan_max = in_data.green_in;
    end
    if (in_data.blue_in > chan_max) begin
      chan_max = in_data.blue_in;
    end
    fr_item_nxt.func     = npc_pkg::npc_func_t'(in_data.func);
    fr_item_nxt.red      = in_data.red_in;
    fr_item_nxt.green    = in_data.green_in;
    fr_item_nxt.blue     = in_data.blue_in;
    fr_item_nxt.alpha    = in_data.alpha_in;
    fr_item_nxt.chan_max = chan_max;
  end

  assign q_push      = fr_valid_r && !q_stat.full;
  assign q_push_data = fr_item_r;
  assign in_ready    = !fr_valid_r || q_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_ready) begin
      fr_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_item_r <= fr_item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/npc_queue.sv =====
// ============================================================================
// npc_queue
// Small first-in first-out queue that decouples the front from the back.
// ============================================================================
`default_nettype none

module npc_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  npc_pkg::npc_qitem_t push_data,
  input  wire                 pop,
  output npc_pkg::npc_qitem_t pop_data,
  output npc_pkg::npc_qstat_t stat
);

  npc_pkg::npc_qitem_t         slot_r [npc_pkg::QDEPTH];
  logic [npc_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [npc_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [npc_pkg::QPTR_W:0]    fill_r;

  assign stat.full  = (fill_r == (npc_pkg::QPTR_W+1)'(npc_pkg::QDEPTH));
  assign stat.empty = (fill_r == '0);
  assign pop_data   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/npc_back.sv =====
// ============================================================================
// npc_back
// Execution stage: appends palette entries, brightens query colors with a
// bit-serial divider and scans the palette through a pipelined root unit.
// ============================================================================
`default_nettype none

module npc_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  npc_pkg::npc_qstat_t q_stat,
  input  npc_pkg::npc_qitem_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output npc_pkg::npc_out_t   out_data
);

  localparam int DW = npc_pkg::DIST_W;
  localparam int NS = npc_pkg::SQRT_STAGES;

  npc_pkg::npc_state_t state_r;
  npc_pkg::npc_state_t state_nxt;

  // Palette storage
  logic [23:0]                 mem [npc_pkg::PALETTE_DEPTH];
  logic [npc_pkg::CNT_W-1:0]   count_r;
  logic [23:0]                 mem_rd_r;
  logic                        rd_vld_r;

  // Control decoded from state
  logic mem_we;
  logic load_query;
  logic div_step;
  logic issue;
  logic out_load;
  logic pipe_busy;
  logic room;

  // Brightening divider
  logic [npc_pkg::NUM_W-1:0] rem_r [3];
  logic [npc_pkg::QUO_W-1:0] quo_r [3];
  logic [npc_pkg::NUM_W-1:0] num   [3];
  logic [7:0]                chan  [3];
  logic [15:0]               den_sh_r;
  logic [2:0]                div_cnt_r;
  logic                      black_r;
  logic [7:0]                alpha_r;
  logic [7:0]                qtgt  [3];

  // Scan
  logic [npc_pkg::CNT_W-1:0] scan_idx_r;

  // Distance stages
  logic [15:0]  sq_r [3];
  logic [23:0]  ent1_r;
  logic         v1_r;
  logic [DW-1:0] sum_r;
  logic [23:0]  ent2_r;
  logic         v2_r;
  logic [7:0]   diff [3];

  // Root pipeline
  logic [DW-1:0] sv_r   [NS];
  logic [DW-1:0] sr_r   [NS];
  logic [23:0]   sent_r [NS];
  logic          svld_r [NS];
  logic [DW-1:0] sv_nxt [NS];
  logic [DW-1:0] sr_nxt [NS];
  logic [DW-1:0] st_v   [NS];
  logic [DW-1:0] st_r   [NS];

  // Best match
  logic [23:0]               best_r;
  logic [npc_pkg::ERR_W-1:0] best_err_r;
  logic                      found_r;
  logic [npc_pkg::ERR_W-1:0] err;

  logic                      out_valid_r;
  npc_pkg::npc_out_t         out_r;

  assign room = count_r < npc_pkg::CNT_W'(npc_pkg::PALETTE_DEPTH);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      npc_pkg::ST_IDLE: begin
        if (!q_stat.empty && q_data.func == npc_pkg::FUNC_QUERY) begin
          state_nxt = npc_pkg::ST_DIV;
        end
      end
      npc_pkg::ST_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = (count_r == '0) ? npc_pkg::ST_DONE : npc_pkg::ST_SCAN;
        end
      end
      npc_pkg::ST_SCAN: begin
        if (scan_idx_r == npc_pkg::CNT_W'(count_r - 1'b1)) begin
          state_nxt = npc_pkg::ST_DRAIN;
        end
      end
      npc_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = npc_pkg::ST_DONE;
        end
      end
      npc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = npc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = npc_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // State outputs
  // --------------------------------------------------------------------------
  always_comb begin
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    load_query = 1'b0;
    div_step   = 1'b0;
    issue      = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      npc_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (q_data.func == npc_pkg::FUNC_QUERY) begin
            load_query = 1'b1;
          end else begin
            mem_we = room;
          end
        end
      end
      npc_pkg::ST_DIV:   div_step = 1'b1;
      npc_pkg::ST_SCAN:  issue    = 1'b1;
      npc_pkg::ST_DRAIN: ;
      npc_pkg::ST_DONE:  out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Palette append and read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (mem_we) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[npc_pkg::ADDR_W-1:0]] <= {q_data.red, q_data.green, q_data.blue};
    end
    if (issue) begin
      mem_rd_r <= mem[scan_idx_r[npc_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else if (load_query) begin
      scan_idx_r <= '0;
    end else if (issue) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Brightening: round(255*c/m) as floor((510*c + m) / (2*m)), one quotient
  // bit per cycle for all three channels against a shared divisor.
  // --------------------------------------------------------------------------
  assign chan[0] = q_data.red;
  assign chan[1] = q_data.green;
  assign chan[2] = q_data.blue;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c] = npc_pkg::NUM_W'(npc_pkg::NUM_W'(chan[c]) *
                               npc_pkg::NUM_W'({npc_pkg::CHAN_FULL, 1'b0}))
             + npc_pkg::NUM_W'(q_data.chan_max);
    end
  end

  always_ff @(posedge clk) begin
    if (load_query) begin
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= num[c];
        quo_r[c] <= '0;
      end
      den_sh_r  <= {q_data.chan_max, 1'b0, 7'b0};
      div_cnt_r <= 3'd7;
      black_r   <= (q_data.chan_max == '0);
      alpha_r   <= q_data.alpha;
    end else if (div_step) begin
      for (int c = 0; c < 3; c++) begin
        if (rem_r[c] >= npc_pkg::NUM_W'(den_sh_r)) begin
          rem_r[c] <= rem_r[c] - npc_pkg::NUM_W'(den_sh_r);
          quo_r[c] <= {quo_r[c][npc_pkg::QUO_W-2:0], 1'b1};
        end else begin
          quo_r[c] <= {quo_r[c][npc_pkg::QUO_W-2:0], 1'b0};
        end
      end
      den_sh_r  <= den_sh_r >> 1;
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  // A black query stays black.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qtgt[c] = black_r ? 8'd0 : quo_r[c];
    end
  end

  // --------------------------------------------------------------------------
  // Distance: absolute differences and squares, then their sum
  // --------------------------------------------------------------------------
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (mem_rd_r[16-8*c +: 8] >= qtgt[c]) begin
        diff[c] = mem_rd_r[16-8*c +: 8] - qtgt[c];
      end else begin
        diff[c] = qtgt[c] - mem_rd_r[16-8*c +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      sq_r[c] <= 16'(diff[c]) * 16'(diff[c]);
    end
    ent1_r <= mem_rd_r;
    sum_r  <= DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]);
    ent2_r <= ent1_r;
  end

  // --------------------------------------------------------------------------
  // Floor square root, one result bit per stage
  // --------------------------------------------------------------------------
  always_comb begin
    st_v[0] = sum_r;
    st_r[0] = '0;
    for (int s = 1; s < NS; s++) begin
      st_v[s] = sv_r[s-1];
      st_r[s] = sr_r[s-1];
    end
  end

  always_comb begin
    logic [DW:0]   trial;
    logic [DW-1:0] bitv;
    for (int s = 0; s < NS; s++) begin
      bitv  = DW'(1) << (2 * (NS - 1 - s));
      trial = (DW+1)'(st_r[s]) + (DW+1)'(bitv);
      if ((DW+1)'(st_v[s]) >= trial) begin
        sv_nxt[s] = DW'((DW+1)'(st_v[s]) - trial);
        sr_nxt[s] = (st_r[s] >> 1) + bitv;
      end else begin
        sv_nxt[s] = st_v[s];
        sr_nxt[s] = st_r[s] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      sv_r[s] <= sv_nxt[s];
      sr_r[s] <= sr_nxt[s];
    end
    sent_r[0] <= ent2_r;
    for (int s = 1; s < NS; s++) begin
      sent_r[s] <= sent_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      for (int s = 0; s < NS; s++) begin
        svld_r[s] <= 1'b0;
      end
    end else begin
      rd_vld_r  <= issue;
      v1_r      <= rd_vld_r;
      v2_r      <= v1_r;
      svld_r[0] <= v2_r;
      for (int s = 1; s < NS; s++) begin
        svld_r[s] <= svld_r[s-1];
      end
    end
  end

  always_comb begin
    pipe_busy = rd_vld_r || v1_r || v2_r;
    for (int s = 0; s < NS; s++) begin
      pipe_busy = pipe_busy || svld_r[s];
    end
  end

  // --------------------------------------------------------------------------
  // Best match: strict compare keeps the earliest entry on a tie
  // --------------------------------------------------------------------------
  assign err = sr_r[NS-1][npc_pkg::ERR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (load_query) begin
      found_r <= 1'b0;
    end else if (svld_r[NS-1]) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_query) begin
      best_r <= '0;
    end else if (svld_r[NS-1] && (!found_r || err < best_err_r)) begin
      best_r     <= sent_r[NS-1];
      best_err_r <= err;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.red_out   <= best_r[23:16];
      out_r.green_out <= best_r[15:8];
      out_r.blue_out  <= best_r[7:0];
      out_r.alpha_out <= alpha_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== sv/nearest_palette_color_top.sv =====
// ============================================================================
// nearest_palette_color_top
// Palette of RGB colors with nearest-color lookup by Euclidean distance.
// ============================================================================
// Usage:
// Words enter on the in_ channel (valid/ready). A word with func clear appends
// its color to the palette; once the palette holds 256 colors further appends
// are dropped. A word with func set is a query: its color is brightened so its
// largest channel becomes 255 (a black query stays black), the palette is
// scanned in order, and one result word on the out_ channel carries the first
// entry with the smallest rounded-down distance, with the query's alpha, or
// black if the palette is empty. Appends give no result word. An append is
// taken at one word per cycle while no query is in progress. A query passes
// through a serial divider, then the single palette read port at one entry
// per cycle, then the distance and square-root pipeline draining. With an
// empty palette the scan is skipped. Queries run one at a time. A four-word
// queue and an input register keep accepting words while the back end works
// or while a result waits. When the receiver stalls, the result stays in the
// output register and the back end holds back its next result. Reset empties
// the palette and all queues; no clearing pass is needed.
// ============================================================================
`default_nettype none

module nearest_palette_color_top (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  npc_pkg::npc_in_t   in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output npc_pkg::npc_out_t  out_data
);

  logic                q_push;
  logic                q_pop;
  npc_pkg::npc_qitem_t q_push_data;
  npc_pkg::npc_qitem_t q_pop_data;
  npc_pkg::npc_qstat_t q_stat;

  npc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_push      (q_push),
    .q_push_data (q_push_data),
    .q_stat      (q_stat)
  );

  npc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  npc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The front never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  // The back never takes a word from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  // No result word is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

`default_nettype wire
